@@ rtl/irt_pkg.sv @@
`default_nettype none
package irt_pkg;
    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_SETLT  = 3'd3;
    localparam logic [2:0] OP_SETST  = 3'd4;
    localparam logic [2:0] OP_SETEND = 3'd5;
    localparam logic [2:0] OP_EXPIRE = 3'd6;
    localparam logic [2:0] OP_CLEAR  = 3'd7;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_BADARG   = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_OVERLAP  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] sender_node;
        logic [31:0] receiver_node;
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic [31:0] light_time;
        logic [31:0] probe_time;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_light_time;
        logic [31:0] next_expiry;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [31:0] sender;
        logic [31:0] receiver;
        logic [31:0] start;
        logic [31:0] end_t;
        logic [31:0] light;
    } t_entry;
endpackage
`default_nettype wire

@@ rtl/irt_if.sv @@
`default_nettype none
interface irt_req_if import irt_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface irt_rsp_if import irt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/interval_range_table.sv @@
// Interval range table: keyed by sender, receiver and start time, each
// interval holding an end time and a light time.
// Channels: i_req (sink) carries one operation request; o_rsp (source)
// returns exactly one result per request: status, light time found by a
// lookup, and the earliest end time among valid entries after the step.
// Each request walks the table (TableDepth = 64 entries) one entry per
// cycle through a single read port and comparator set, with a registered
// read. Lookup, expire and clear take one pass (expire writes back as it
// goes); add, remove and set light time pass once more for the earliest
// end; set start and set end take a key pass, a clash pass and a final
// pass. A key operation rejected in the key pass, or a revise rejected in
// the clash pass, stops there. The next request is taken only after the
// result is taken and the block is back in idle.
// The block is not ready while a request is in flight or while a result
// waits; a stalled receiver holds the result and blocks new requests.
// Reset (synchronous, active low) clears every valid mark and sets the
// next expiry to all ones; entry contents are not cleared.
`default_nettype none
module interval_range_table import irt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    irt_req_if.sink   i_req,
    irt_rsp_if.source o_rsp
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CLASH = 3'd2;
    localparam logic [2:0] S_MIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    t_req r_req;
    logic [CntW-1:0] r_cnt, n_cnt;        // read address counter
    logic [IdxW-1:0] r_k, n_k;
    logic r_hit, n_hit;
    logic r_free_ok, n_free_ok;
    logic [IdxW-1:0] r_free, n_free;
    logic r_clash, n_clash;
    logic [31:0] r_kstart, n_kstart, r_kend, n_kend;
    logic [31:0] r_min, n_min, r_expiry, n_expiry;
    logic [2:0] r_status, n_status;
    logic [31:0] r_found, n_found;
    logic r_rvalid;                       // read data refers to r_cnt-1
    logic [IdxW-1:0] r_ridx;

    t_entry rd, wr;
    logic wr_en, clr_all;
    logic [IdxW-1:0] wr_idx, rd_idx;

    irt_store u_store (
        .i_clk, .i_rst_n, .i_rd_idx(rd_idx), .o_rd(rd),
        .i_wr_en(wr_en), .i_wr_idx(wr_idx), .i_wr(wr), .i_clr_all(clr_all)
    );

    logic [31:0] e_add;
    logic nodes_bad, pair, last_rd, issuing;
    logic [31:0] cs, ce;

    assign e_add = (r_req.end_time == '0) ? ALL_ONES : r_req.end_time;
    assign nodes_bad = (r_req.sender_node == '0) || (r_req.receiver_node == '0);
    assign pair = rd.valid && rd.sender == r_req.sender_node
                  && rd.receiver == r_req.receiver_node;
    assign issuing = (r_cnt < CntW'(TableDepth));
    assign rd_idx = r_cnt[IdxW-1:0];
    assign last_rd = r_rvalid && (r_ridx == IdxW'(TableDepth - 1));

    always_comb begin
        unique case (r_req.opcode)
            OP_SETST:  begin cs = r_req.probe_time; ce = r_kend; end
            OP_SETEND: begin cs = r_kstart; ce = r_req.probe_time; end
            default:   begin cs = r_req.start_time; ce = e_add; end
        endcase
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_k = r_k; n_hit = r_hit;
        n_free_ok = r_free_ok; n_free = r_free; n_clash = r_clash;
        n_kstart = r_kstart; n_kend = r_kend; n_min = r_min;
        n_expiry = r_expiry; n_status = r_status; n_found = r_found;
        wr_en = 1'b0; wr_idx = r_ridx; wr = rd; clr_all = 1'b0;
        if (issuing && r_state != S_IDLE && r_state != S_OUT) n_cnt = r_cnt + 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cnt = '0; n_hit = 1'b0; n_free_ok = 1'b0; n_clash = 1'b0;
                    n_min = ALL_ONES; n_found = '0; n_status = ST_DONE;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rvalid) begin
                    case (r_req.opcode)
                        OP_ADD: begin
                            if (pair && (rd.start == cs || (rd.start < ce && cs < rd.end_t)))
                                n_clash = 1'b1;
                            if (!rd.valid && !r_free_ok) begin
                                n_free_ok = 1'b1; n_free = r_ridx;
                            end
                        end
                        OP_LOOKUP: begin
                            if (!r_hit && pair && rd.start <= r_req.probe_time
                                && r_req.probe_time < rd.end_t) begin
                                n_hit = 1'b1; n_found = rd.light;
                            end
                        end
                        OP_EXPIRE: begin
                            if (rd.valid && rd.end_t <= r_req.probe_time) begin
                                wr_en = 1'b1; wr.valid = 1'b0;
                            end else if (rd.valid && rd.end_t < r_min) begin
                                n_min = rd.end_t;
                            end
                        end
                        OP_CLEAR: ;
                        default: begin
                            if (!r_hit && pair && rd.start == r_req.start_time) begin
                                n_hit = 1'b1; n_k = r_ridx;
                                n_kstart = rd.start; n_kend = rd.end_t;
                            end
                        end
                    endcase
                end
                if (last_rd) begin
                    n_cnt = '0;
                    n_state = S_MIN;
                    unique case (r_req.opcode)
                        OP_ADD: begin
                            if (nodes_bad || e_add < r_req.start_time) n_status = ST_BADARG;
                            else if (n_clash) n_status = ST_OVERLAP;
                            else if (!n_free_ok) n_status = ST_FULL;
                            else begin
                                wr_en = 1'b1; wr_idx = n_free;
                                wr = {1'b1, r_req.sender_node, r_req.receiver_node,
                                      r_req.start_time, e_add, r_req.light_time};
                            end
                        end
                        OP_LOOKUP: begin
                            if (nodes_bad || !n_hit) begin
                                n_status = ST_NOTFOUND; n_found = '0;
                            end
                            n_state = S_OUT; n_expiry = r_expiry;
                        end
                        OP_EXPIRE: begin n_state = S_OUT; n_expiry = n_min; end
                        OP_CLEAR: begin
                            clr_all = 1'b1; n_state = S_OUT; n_expiry = ALL_ONES;
                        end
                        default: begin
                            if (nodes_bad) n_status = ST_BADARG;
                            else if (!n_hit) n_status = ST_NOTFOUND;
                            else if (r_req.opcode == OP_REMOVE) begin
                                wr_en = 1'b1; wr_idx = n_k; wr.valid = 1'b0;
                            end else if (r_req.opcode == OP_SETLT) begin
                                wr_en = 1'b1; wr_idx = n_k;
                                wr = {1'b1, r_req.sender_node, r_req.receiver_node,
                                      n_kstart, n_kend, r_req.light_time};
                            end else if (r_req.opcode == OP_SETST
                                         && r_req.probe_time > n_kend)
                                n_status = ST_BADARG;
                            else if (r_req.opcode == OP_SETEND
                                     && r_req.probe_time < n_kstart)
                                n_status = ST_BADARG;
                            else n_state = S_CLASH;
                            if (n_status != ST_DONE) begin
                                n_state = S_OUT; n_expiry = r_expiry;
                            end
                        end
                    endcase
                end
            end
            S_CLASH: begin
                if (r_rvalid && r_ridx != r_k && pair
                    && (rd.start == cs || (rd.start < ce && cs < rd.end_t)))
                    n_clash = 1'b1;
                if (last_rd) begin
                    n_cnt = '0;
                    if (n_clash) begin
                        n_status = ST_OVERLAP; n_state = S_OUT; n_expiry = r_expiry;
                    end else begin
                        wr_en = 1'b1; wr_idx = r_k;
                        wr = {1'b1, r_req.sender_node, r_req.receiver_node, cs, ce,
                              rd.light};
                        n_state = S_MIN;
                        // keep the light time of slot k captured in the key pass
                        wr.light = r_found;
                    end
                end
            end
            S_MIN: begin
                if (r_rvalid && rd.valid && rd.end_t < r_min) n_min = rd.end_t;
                if (last_rd) begin
                    n_expiry = (rd.valid && rd.end_t < r_min) ? rd.end_t : r_min;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // capture light time of the keyed entry for the clash write back
        if (r_state == S_SCAN && r_rvalid && !r_hit && pair
            && rd.start == r_req.start_time
            && r_req.opcode != OP_ADD && r_req.opcode != OP_LOOKUP
            && r_req.opcode != OP_EXPIRE && r_req.opcode != OP_CLEAR)
            n_found = rd.light;
        if (n_state == S_OUT && r_state != S_OUT && r_req.opcode != OP_LOOKUP)
            n_found = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_expiry <= ALL_ONES;
            r_rvalid <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_expiry <= n_expiry;
            r_cnt <= n_cnt;
            r_rvalid <= (n_state != S_IDLE && n_state != S_OUT && r_state == n_state
                         && issuing);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) r_req <= i_req.payload;
        r_ridx <= rd_idx;
        r_k <= n_k; r_hit <= n_hit; r_free_ok <= n_free_ok; r_free <= n_free;
        r_clash <= n_clash; r_kstart <= n_kstart; r_kend <= n_kend;
        r_min <= n_min; r_status <= n_status; r_found <= n_found;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.payload = {r_status, r_found, r_expiry};
endmodule
`default_nettype wire

@@ rtl/irt_store.sv @@
`default_nettype none
module irt_store import irt_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [IdxW-1:0] i_rd_idx,
    output t_entry               o_rd,
    input  wire logic            i_wr_en,
    input  wire logic [IdxW-1:0] i_wr_idx,
    input  wire t_entry          i_wr,
    input  wire logic            i_clr_all
);
    logic [TableDepth-1:0] r_valid;
    logic [159:0] r_mem [TableDepth];
    logic [159:0] r_rd_data;
    logic r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr.sender, i_wr.receiver, i_wr.start, i_wr.end_t, i_wr.light};
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clr_all) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_idx] <= i_wr.valid;
            end
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    assign o_rd = {r_rd_valid, r_rd_data};
endmodule
`default_nettype wire

@@ rtl/irt_checker.sv @@
`default_nettype none
module irt_checker import irt_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp i_rsp
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_ready && i_rsp_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready) else $error("ready after request");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp.status <= ST_FULL) else $error("bad status");
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status != ST_DONE |-> i_rsp.found_light_time == '0)
        else $error("light time on failure");
endmodule

bind interval_range_table irt_checker u_irt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready), .i_rsp(o_rsp.payload)
);
`default_nettype wire
